FILE: hdl/lcddpr_pkg.sv
// Shared constants and types for the LCD dirty page refresh unit.
package lcddpr_pkg;

    localparam int WIDTH_DEF = 128;
    localparam int PAGES_DEF = 8;

    localparam int PAGE_MAX_W = 4;

    localparam logic [1:0] PH_INIT = 2'd0;
    localparam logic [1:0] PH_ADDR = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    localparam logic [1:0] ACT_WRITE    = 2'd0;
    localparam logic [1:0] ACT_MARK_ALL = 2'd1;
    localparam logic [1:0] ACT_SLOT     = 2'd2;

    localparam logic [2:0] REG_INIT_BYTES  = 3'd0;
    localparam logic [2:0] REG_INIT_COUNT  = 3'd1;
    localparam logic [2:0] REG_PAGE_BASE   = 3'd2;
    localparam logic [2:0] REG_COL_HIGH    = 3'd3;
    localparam logic [2:0] REG_COL_LOW     = 3'd4;
    localparam logic [2:0] REG_REVERSE     = 3'd5;

    localparam logic [63:0] INIT_BYTES_RST = 64'h0;
    localparam logic [3:0]  INIT_COUNT_RST = 4'd1;
    localparam logic [7:0]  PAGE_BASE_RST  = 8'd176;
    localparam logic [7:0]  COL_HIGH_RST   = 8'd16;
    localparam logic [7:0]  COL_LOW_RST    = 8'd0;

    typedef struct packed {
        logic                  found;
        logic [PAGE_MAX_W-1:0] page;
    } pick_t;

endpackage

FILE: hdl/lcddpr_page_pick.sv
// Round-robin search for the next dirty page starting at the scan pointer.
module lcddpr_page_pick
    import lcddpr_pkg::*;
#(
    parameter int PAGES = PAGES_DEF,
    parameter int PG_W  = (PAGES > 1) ? $clog2(PAGES) : 1
)
(
    input  logic [PAGES-1:0] flags,
    input  logic [PG_W-1:0]  scan,
    output pick_t            pick
);

    always_comb
    begin
        logic [PAGE_MAX_W:0] idx;
        pick = '0;
        for (int i = PAGES - 1; i >= 0; i--)
        begin
            idx = (PAGE_MAX_W + 1)'(scan) + (PAGE_MAX_W + 1)'(i);
            if (idx >= (PAGE_MAX_W + 1)'(PAGES))
            begin
                idx = idx - (PAGE_MAX_W + 1)'(PAGES);
            end
            if (flags[idx[PG_W-1:0]])
            begin
                pick.found = 1'b1;
                pick.page  = idx[PAGE_MAX_W-1:0];
            end
        end
    end

endmodule

FILE: hdl/lcd_dirty_page_refresh_unit.sv
// Top level of the LCD dirty page refresh unit: frame buffer, page scan and byte feed.
//
//  channel  direction  signals                      beat contents
//  s_*      in         s_tvalid s_tready s_tdata     tuser: action; tdata: page column value
//                      s_tuser
//  m_*      out        m_tvalid m_tready m_tdata     tdata: out_byte; tuser: is_data
//                      m_tuser                       group_start idle
//  cfg_*    in         cfg_valid cfg_ready           register index and write data
//                      cfg_index cfg_data
//
// One input beat per cycle while s_tready is high; a transmit slot result appears in the
// output register in the cycle after its beat is taken, data bytes coming from the registered
// buffer read port. After reset the buffer is cleared one byte a cycle, all PAGES*WIDTH bytes
// (1024 by default), while s_tready stays low; configuration writes are taken throughout.
// s_tready follows the output register: it is high when that register is empty or drains.
module lcd_dirty_page_refresh_unit
    import lcddpr_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF,
    parameter int PAGES = PAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // page[2:0], column[9:3], value[17:10], zero fill
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic [2:0]  m_tuser,   // is_data[0], group_start[1], idle[2]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int DEPTH = PAGES * WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(WIDTH);
    localparam int PG_W  = (PAGES > 1) ? $clog2(PAGES) : 1;

    logic [63:0]      init_bytes_reg;
    logic [3:0]       init_count_reg;
    logic [7:0]       page_base_reg;
    logic [7:0]       col_high_reg;
    logic [7:0]       col_low_reg;
    logic             reverse_reg;

    logic [1:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PG_W-1:0]  scan_reg, scan_next;
    logic [PG_W-1:0]  cur_page_reg, cur_page_next;
    logic [PAGES-1:0] dirty_reg, dirty_next;

    logic             clearing_reg;
    logic [AW-1:0]    clr_addr_reg;

    logic             out_valid_reg;
    logic [7:0]       byte_reg, byte_next;
    logic             is_data_reg, is_data_next;
    logic             start_reg, start_next;
    logic             idle_reg, idle_next;

    logic [7:0]       mem [DEPTH];
    logic [7:0]       mem_q_reg;

    logic [1:0]       action;
    logic [2:0]       in_page;
    logic [6:0]       in_column;
    logic [7:0]       in_value;
    logic             accept;
    logic             in_range;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [CNT_W-1:0] data_col;
    logic [3:0]       init_len;
    logic             emit;
    pick_t            pick;
    logic [PG_W-1:0]  pick_page;

    assign action    = s_tuser;
    assign in_page   = s_tdata[2:0];
    assign in_column = s_tdata[9:3];
    assign in_value  = s_tdata[17:10];

    assign s_tready  = !clearing_reg && (!out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_range  = (5'(in_page) < 5'(PAGES)) && (9'(in_column) < 9'(WIDTH));
    assign data_col  = reverse_reg ? (CNT_W'(WIDTH - 1) - count_reg) : count_reg;
    assign pick_page = pick.page[PG_W-1:0];

    always_comb
    begin
        if (init_count_reg == 4'd0)
        begin
            init_len = 4'd1;
        end
        else if (init_count_reg > 4'd8)
        begin
            init_len = 4'd8;
        end
        else
        begin
            init_len = init_count_reg;
        end
    end

    lcddpr_page_pick #(
        .PAGES (PAGES),
        .PG_W  (PG_W)
    ) u_pick (
        .flags (dirty_reg),
        .scan  (scan_reg),
        .pick  (pick)
    );

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        cur_page_next = cur_page_reg;
        dirty_next    = dirty_reg;
        emit          = 1'b0;
        byte_next     = 8'd0;
        is_data_next  = 1'b0;
        start_next    = 1'b0;
        idle_next     = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = AW'(cur_page_reg) * AW'(WIDTH) + AW'(data_col);

        if (accept)
        begin
            case (action)
                ACT_WRITE:
                begin
                    for (int i = 0; i < PAGES; i++)
                    begin
                        if (in_range && (5'(in_page) == 5'(i)))
                        begin
                            dirty_next[i] = 1'b1;
                        end
                    end
                end
                ACT_MARK_ALL:
                begin
                    dirty_next = '1;
                end
                ACT_SLOT:
                begin
                    emit = 1'b1;
                    case (phase_reg)
                        PH_INIT:
                        begin
                            byte_next  = init_bytes_reg[{count_reg[2:0], 3'b000} +: 8];
                            start_next = (count_reg == '0);
                            if ((4'(count_reg[2:0]) + 4'd1) >= init_len)
                            begin
                                count_next = '0;
                                phase_next = PH_ADDR;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        PH_DATA:
                        begin
                            rd_en        = 1'b1;
                            is_data_next = 1'b1;
                            start_next   = (count_reg == '0);
                            if (count_reg == CNT_W'(WIDTH - 1))
                            begin
                                count_next = '0;
                                phase_next = PH_ADDR;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        PH_ADDR:
                        begin
                            if (count_reg == CNT_W'(0))
                            begin
                                if (!pick.found)
                                begin
                                    scan_next = '0;
                                    idle_next = 1'b1;
                                end
                                else
                                begin
                                    byte_next  = page_base_reg + 8'(pick.page);
                                    start_next = 1'b1;
                                    dirty_next[pick_page] = 1'b0;
                                    cur_page_next = pick_page;
                                    if (5'(pick.page) == 5'(PAGES - 1))
                                    begin
                                        scan_next = '0;
                                    end
                                    else
                                    begin
                                        scan_next = pick_page + PG_W'(1);
                                    end
                                    count_next = CNT_W'(1);
                                end
                            end
                            else if (count_reg == CNT_W'(1))
                            begin
                                byte_next  = col_high_reg;
                                count_next = CNT_W'(2);
                            end
                            else
                            begin
                                byte_next  = col_low_reg;
                                count_next = '0;
                                phase_next = PH_DATA;
                            end
                        end
                        default:
                        begin
                            idle_next = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = 8'd0;
        end
        else
        begin
            wr_en   = accept && (action == ACT_WRITE) && in_range;
            wr_addr = AW'(in_page) * AW'(WIDTH) + AW'(in_column);
            wr_data = in_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_bytes_reg <= INIT_BYTES_RST;
            init_count_reg <= INIT_COUNT_RST;
            page_base_reg  <= PAGE_BASE_RST;
            col_high_reg   <= COL_HIGH_RST;
            col_low_reg    <= COL_LOW_RST;
            reverse_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_INIT_BYTES: init_bytes_reg <= cfg_data;
                REG_INIT_COUNT: init_count_reg <= cfg_data[3:0];
                REG_PAGE_BASE:  page_base_reg  <= cfg_data[7:0];
                REG_COL_HIGH:   col_high_reg   <= cfg_data[7:0];
                REG_COL_LOW:    col_low_reg    <= cfg_data[7:0];
                REG_REVERSE:    reverse_reg    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_INIT;
            count_reg     <= '0;
            scan_reg      <= '0;
            cur_page_reg  <= '0;
            dirty_reg     <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            cur_page_reg <= cur_page_next;
            dirty_reg    <= dirty_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg    <= byte_next;
            is_data_reg <= is_data_next;
            start_reg   <= start_next;
            idle_reg    <= idle_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = is_data_reg ? mem_q_reg : byte_reg;
    assign m_tuser  = {idle_reg, start_reg, is_data_reg};

endmodule
